FILE: hdl/pmst_pkg.sv
// shared constants, codes and types of the minimum spanning tree block
package pmst_pkg;

  localparam int MAX_NODES      = 64;
  localparam int NODE_BITS      = $clog2(MAX_NODES);
  localparam int WEIGHT_BITS    = 16;
  localparam int CNT_W          = 7;
  localparam int MAT_DEPTH      = 2 ** (2 * NODE_BITS);
  localparam int FIELD_IDX_W    = 6;
  localparam int FIELD_WEIGHT_W = 16;
  localparam int TDATA_W        = 32;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 64;

  localparam logic [CNT_W-1:0] NODE_COUNT_RST = CNT_W'(64);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ALIVE_MASK = CFG_IDX_W'(1);

  // input word kinds
  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_COMPUTE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RELAX,
    ST_DRAIN,
    ST_PICK,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  typedef struct packed {
    logic [WEIGHT_BITS-1:0] cost;
    logic [NODE_BITS-1:0]   parent;
  } node_ent_t;

  typedef struct packed {
    logic                 valid;
    logic [NODE_BITS-1:0] v;
    logic [NODE_BITS-1:0] u;
    logic                 tree_v;
    logic                 fin_v;
    logic                 alive_uv;
  } relax_req_t;

  typedef struct packed {
    logic                 we;
    logic [NODE_BITS-1:0] addr;
    node_ent_t            ent;
  } relax_wr_t;

  typedef struct packed {
    logic                   found;
    logic [NODE_BITS-1:0]   idx;
    logic [WEIGHT_BITS-1:0] cost;
  } min_t;

endpackage

FILE: hdl/pmst_relax.sv
// relax step for one neighbor plus running minimum over the unvisited nodes
module pmst_relax (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  pmst_pkg::relax_req_t                 req,
  input  logic [pmst_pkg::WEIGHT_BITS-1:0]     mdata,
  input  pmst_pkg::node_ent_t                  ndata,
  output pmst_pkg::relax_wr_t                  wr,
  output pmst_pkg::min_t                       min_o
);
  import pmst_pkg::*;

  logic [WEIGHT_BITS-1:0] e;
  logic [WEIGHT_BITS-1:0] new_cost;
  logic                   relax;
  logic                   cand;
  logic                   first;
  logic                   prev_found;
  logic                   better;
  min_t                   min_r;
  min_t                   min_nxt;

  always_comb begin
    e          = req.alive_uv ? mdata : '0;
    relax      = req.valid && !req.tree_v && (e != '0) && (!req.fin_v || (e < ndata.cost));
    new_cost   = relax ? e : ndata.cost;
    cand       = req.valid && !req.tree_v && (req.fin_v || relax);
    first      = (req.v == '0);
    prev_found = first ? 1'b0 : min_r.found;
    better     = cand && (!prev_found || (new_cost < min_r.cost));

    min_nxt = min_r;
    if (req.valid && first) begin
      min_nxt.found = 1'b0;
    end
    if (better) begin
      min_nxt.found = 1'b1;
      min_nxt.idx   = req.v;
      min_nxt.cost  = new_cost;
    end

    wr.we         = relax;
    wr.addr       = req.v;
    wr.ent.cost   = e;
    wr.ent.parent = req.u;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= '0;
    end else begin
      min_r <= min_nxt;
    end
  end

  assign min_o = min_r;

endmodule

FILE: hdl/prim_minimum_spanning_tree.sv
// top level of the minimum spanning tree block: weight matrix, node table and sequencer
//
// A load word (tuser 0) writes one weight of the 64 x 64 adjacency matrix; loads are
// taken back to back, one per clock, whenever the block is idle. A
// compute word (tuser 1) runs Prim's algorithm from node 0 over the first node_count
// nodes, skipping edges of nodes whose alive_mask bit is clear. Each round is one pass
// through matrix row u: one matrix entry and one node table entry are read per cycle, the
// relax unit writes the improved cost back the cycle after, and the same pass tracks the
// cheapest unvisited node, which becomes u of the next round. A round is n reads, a
// drain and a pick, and there are at most n - 1 rounds, the sweep being bounded by the
// single read port of each memory. A round that finds no reachable node ends the sweep
// early. Results follow, one word per node 1..n-1 in node order with tlast on the final
// one, each read in EMIT_RD and loaded in EMIT_LD, which waits while the output register
// is full. The last result waits in the output register while new words are taken.
// node_count of zero or one gives no results. No clearing pass follows reset: the node
// table is qualified by per-node flag bits held in flops.
module prim_minimum_spanning_tree (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input channel
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // tdata from bit 0: row[5:0], col[5:0], weight[15:0], zero fill
  input  logic [pmst_pkg::TDATA_W-1:0]          in_tdata,
  // tuser: action (0 load weight, 1 compute)
  input  logic                                  in_tuser,
  // result channel
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // tdata from bit 0: node[5:0], parent[5:0], edge_weight[15:0], zero fill
  output logic [pmst_pkg::TDATA_W-1:0]          out_tdata,
  // tuser: has_parent
  output logic                                  out_tuser,
  output logic                                  out_tlast,
  // configuration write channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [pmst_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pmst_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import pmst_pkg::*;

  // input word fields
  logic [FIELD_IDX_W-1:0]    in_row;
  logic [FIELD_IDX_W-1:0]    in_col;
  logic [FIELD_WEIGHT_W-1:0] in_weight;

  assign in_row    = in_tdata[FIELD_IDX_W-1:0];
  assign in_col    = in_tdata[2*FIELD_IDX_W-1:FIELD_IDX_W];
  assign in_weight = in_tdata[2*FIELD_IDX_W+FIELD_WEIGHT_W-1:2*FIELD_IDX_W];

  // configuration registers
  logic [CNT_W-1:0]      node_count_r;
  logic [CFG_DATA_W-1:0] alive_r;

  // sequencer
  state_t state_r;
  state_t state_nxt;

  logic [CNT_W-1:0]     n_r;        // clamped node count of the current run
  logic [CNT_W-1:0]     n_clamp;
  logic [CNT_W-1:0]     round_r;    // rounds started so far
  logic [NODE_BITS-1:0] u_r;        // node joined this round
  logic [NODE_BITS-1:0] v_r;        // read pointer of the pass or of the result walk
  logic [NODE_BITS-1:0] p_v_r;      // node being processed by the relax unit
  logic                 p_valid_r;

  // per-node flags: finite cost (and parent for nodes above 0), visited
  logic [MAX_NODES-1:0] fin_r;
  logic [MAX_NODES-1:0] tree_r;

  // memories
  logic [WEIGHT_BITS-1:0] mat_mem [MAT_DEPTH];
  node_ent_t              node_mem [MAX_NODES];
  logic [WEIGHT_BITS-1:0] mat_rd_r;
  node_ent_t              node_rd_r;

  // output register
  logic                      out_tvalid_r;
  logic [NODE_BITS-1:0]      out_node_r;
  logic [NODE_BITS-1:0]      out_parent_r;
  logic [FIELD_WEIGHT_W-1:0] out_ew_r;
  logic                      out_hp_r;
  logic                      out_last_r;

  // handshake and control decode
  logic       in_acc;
  logic       load_go;
  logic       compute_go;
  logic       load_in_range;
  logic       pass_end;
  logic       sweep_done;
  logic       emit_last;
  logic       out_free;
  logic       issue;
  logic       mat_re;
  logic       node_re;
  logic       out_load;
  relax_req_t req;
  relax_wr_t  wr;
  min_t       min_cur;

  assign in_acc        = in_tvalid && in_tready;
  assign load_go       = in_acc && (in_tuser == ACT_LOAD);
  assign compute_go    = in_acc && (in_tuser == ACT_COMPUTE);
  assign load_in_range = ({1'b0, in_row} < CNT_W'(MAX_NODES))
                      && ({1'b0, in_col} < CNT_W'(MAX_NODES));
  assign n_clamp       = (node_count_r > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count_r;
  assign pass_end      = (CNT_W'(v_r) == (n_r - CNT_W'(1)));
  assign emit_last     = pass_end;
  assign sweep_done    = (round_r == (n_r - CNT_W'(1))) || !min_cur.found;
  assign out_free      = !out_tvalid_r || out_tready;
  assign cfg_ready     = 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (compute_go && (n_clamp > CNT_W'(1))) begin
          state_nxt = ST_RELAX;
        end
      end
      ST_RELAX: begin
        if (pass_end) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_PICK;
      end
      ST_PICK: begin
        state_nxt = sweep_done ? ST_EMIT_RD : ST_RELAX;
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (out_free) begin
          state_nxt = emit_last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    in_tready = 1'b0;
    issue     = 1'b0;
    mat_re    = 1'b0;
    node_re   = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
      end
      ST_RELAX: begin
        issue   = 1'b1;
        mat_re  = 1'b1;
        node_re = 1'b1;
      end
      ST_EMIT_RD: begin
        node_re = 1'b1;
      end
      ST_EMIT_LD: begin
        out_load = out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      node_count_r <= NODE_COUNT_RST;
      alive_r      <= '1;
      fin_r        <= '0;
      tree_r       <= '0;
      p_valid_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      p_valid_r <= issue;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_NODE_COUNT: node_count_r <= cfg_data[CNT_W-1:0];
          REG_ALIVE_MASK: alive_r      <= cfg_data;
          default: ;
        endcase
      end

      // a run starts with only the root reached and visited
      if (compute_go) begin
        fin_r  <= MAX_NODES'(1);
        tree_r <= MAX_NODES'(1);
      end else begin
        if (wr.we) begin
          fin_r[wr.addr] <= 1'b1;
        end
        if ((state_r == ST_PICK) && !sweep_done) begin
          tree_r[min_cur.idx] <= 1'b1;
        end
      end

      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // counters and pointers, set at the start of every run
  always_ff @(posedge clk) begin
    p_v_r <= v_r;
    case (state_r)
      ST_IDLE: begin
        if (compute_go) begin
          n_r     <= n_clamp;
          u_r     <= '0;
          v_r     <= '0;
          round_r <= CNT_W'(1);
        end
      end
      ST_RELAX: begin
        v_r <= v_r + NODE_BITS'(1);
      end
      ST_PICK: begin
        u_r     <= min_cur.idx;
        v_r     <= sweep_done ? NODE_BITS'(1) : '0;
        round_r <= round_r + CNT_W'(1);
      end
      ST_EMIT_LD: begin
        if (out_free) begin
          v_r <= v_r + NODE_BITS'(1);
        end
      end
      default: ;
    endcase
  end

  // weight matrix: written by loads, one row swept per round
  always_ff @(posedge clk) begin
    if (load_go && load_in_range) begin
      mat_mem[{in_row[NODE_BITS-1:0], in_col[NODE_BITS-1:0]}] <= WEIGHT_BITS'(in_weight);
    end
    if (mat_re) begin
      mat_rd_r <= mat_mem[{u_r, v_r}];
    end
  end

  // node table: best cost and parent, valid only where fin_r is set
  always_ff @(posedge clk) begin
    if (wr.we) begin
      node_mem[wr.addr] <= wr.ent;
    end
    if (node_re) begin
      node_rd_r <= node_mem[v_r];
    end
  end

  // relax request for the entry read last cycle
  always_comb begin
    req.valid    = p_valid_r;
    req.v        = p_v_r;
    req.u        = u_r;
    req.tree_v   = tree_r[p_v_r];
    req.fin_v    = fin_r[p_v_r];
    req.alive_uv = alive_r[u_r] && alive_r[p_v_r];
  end

  pmst_relax u_relax (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .mdata (mat_rd_r),
    .ndata (node_rd_r),
    .wr    (wr),
    .min_o (min_cur)
  );

  // result word; an unreached node reports a zero parent and weight
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_node_r   <= v_r;
      out_hp_r     <= fin_r[v_r];
      out_parent_r <= fin_r[v_r] ? node_rd_r.parent : '0;
      out_ew_r     <= fin_r[v_r] ? FIELD_WEIGHT_W'(node_rd_r.cost) : '0;
      out_last_r   <= emit_last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_hp_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = TDATA_W'({out_ew_r, FIELD_IDX_W'(out_parent_r), FIELD_IDX_W'(out_node_r)});

  // no read of the node table hits the entry being written back
  assert property (@(posedge clk) disable iff (!rst_n)
    (wr.we && node_re) |-> (wr.addr != v_r))
    else $error("node table read and write-back collide");

  // the picked node was never visited before
  assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_PICK) && min_cur.found) |-> !tree_r[min_cur.idx])
    else $error("minimum search picked a visited node");

  // every visited node has a finite cost
  assert property (@(posedge clk) disable iff (!rst_n)
    (tree_r & ~fin_r) == '0)
    else $error("visited node without finite cost");

  // the relax unit only works during a pass
  assert property (@(posedge clk) disable iff (!rst_n)
    p_valid_r |-> ((state_r == ST_RELAX) || (state_r == ST_DRAIN)))
    else $error("relax step outside a pass");

endmodule
